// ===== sv/lru_pft_pkg.sv =====
// shared constants and inter-module structs for the lru page frame table
package lru_pft_pkg;

  localparam int FRAMES_DEF    = 8;
  localparam int PAGE_BITS_DEF = 16;

  // widest supported page and frame index, structs are sized for these
  localparam int PAGE_MAX_BITS = 32;
  localparam int IDX_MAX_BITS  = 6;

  localparam int CFG_BITS = 4;
  localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

  // running search result handed from cell to cell
  typedef struct packed {
    logic                     found;
    logic [IDX_MAX_BITS-1:0]  fidx;
    logic [IDX_MAX_BITS-1:0]  frank;
    logic                     empty;
    logic [IDX_MAX_BITS-1:0]  eidx;
    logic [IDX_MAX_BITS-1:0]  vidx;
    logic [IDX_MAX_BITS-1:0]  vrank;
    logic [PAGE_MAX_BITS-1:0] vpage;
  } carry_t;

  // update broadcast to every cell once the search is done
  typedef struct packed {
    logic                     en;
    logic                     wr;
    logic [IDX_MAX_BITS-1:0]  f;
    logic [IDX_MAX_BITS:0]    lim;
    logic [PAGE_MAX_BITS-1:0] page;
  } upd_t;

endpackage

// ===== sv/lru_pft_cell.sv =====
// one page frame: holds page, valid and age, and folds itself into the search carry
module lru_pft_cell #(
  parameter int FRAMES    = lru_pft_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pft_pkg::PAGE_BITS_DEF,
  parameter int IDX       = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tok_in,
  input  lru_pft_pkg::carry_t           carry_in,
  input  logic [PAGE_BITS-1:0]          req_page,
  input  logic [$clog2(FRAMES+1)-1:0]   n,
  input  lru_pft_pkg::upd_t             upd,
  output logic                          tok_out,
  output lru_pft_pkg::carry_t           carry_out
);

  localparam int RW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW = $clog2(FRAMES+1);
  localparam int XW = lru_pft_pkg::IDX_MAX_BITS;
  localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES-1);
  localparam logic [NW-1:0] IDX_N    = NW'(IDX);
  localparam logic [RW-1:0] IDX_R    = RW'(IDX);

  logic [PAGE_BITS-1:0] page_q;
  logic                 valid;
  logic [RW-1:0]        rank;
  logic                 active;
  lru_pft_pkg::carry_t  carry_next;

  assign active = IDX_N < n;

  always_comb begin
    carry_next = carry_in;
    if (active) begin
      if (!carry_in.found && valid && page_q == req_page) begin
        carry_next.found = 1'b1;
        carry_next.fidx  = XW'(IDX);
        carry_next.frank = XW'(rank);
      end
      if (!carry_in.empty && !valid) begin
        carry_next.empty = 1'b1;
        carry_next.eidx  = XW'(IDX);
      end
      // strictly older wins, so the lowest index keeps a tie
      if (IDX == 0 || rank > carry_in.vrank[RW-1:0]) begin
        carry_next.vidx  = XW'(IDX);
        carry_next.vrank = XW'(rank);
        carry_next.vpage = lru_pft_pkg::PAGE_MAX_BITS'(page_q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in) begin
      carry_out <= carry_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      rank  <= '0;
    end else if (upd.en && active) begin
      if (upd.f[RW-1:0] == IDX_R) begin
        rank <= '0;
        if (upd.wr) begin
          valid <= 1'b1;
        end
      end else if (valid && {1'b0, rank} < upd.lim[RW:0] && rank < RANK_MAX) begin
        rank <= rank + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en && active && upd.wr && upd.f[RW-1:0] == IDX_R) begin
      page_q <= upd.page[PAGE_BITS-1:0];
    end
  end

endmodule

// ===== sv/lru_page_frame_table_core.sv =====
// lru page frame table: a row of frame cells scanned one cell per cycle, then updated at once
// one request at a time: req_stall holds off a new request until the search token has walked
// the cell row and the update is done
// a waiting result sits in the output register; the next search runs but its update waits
// reset: synchronous, empties all frames, clears ages and sets frames_in_use to 8
module lru_page_frame_table_core #(
  parameter int FRAMES    = lru_pft_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pft_pkg::PAGE_BITS_DEF,
  localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [lru_pft_pkg::CFG_BITS-1:0] cfg_wr_data,
  input  logic                             req_valid,
  output logic                             req_stall,
  input  logic [PAGE_BITS-1:0]             page,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic                             hit,
  output logic [IW-1:0]                    frame_index,
  output logic                             evicted_valid,
  output logic [PAGE_BITS-1:0]             evicted_page
);

  localparam int NW = $clog2(FRAMES+1);
  localparam int XW = lru_pft_pkg::IDX_MAX_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]                       state;
  logic [1:0]                       state_next;
  logic [lru_pft_pkg::CFG_BITS-1:0] frames_in_use;
  logic [NW-1:0]                    n;
  logic [PAGE_BITS-1:0]             req_page;
  logic                             start;
  logic                             accept;
  logic                             slot_free;
  lru_pft_pkg::carry_t              carry_w [FRAMES+1];
  logic                             tok_w   [FRAMES+1];
  lru_pft_pkg::carry_t              c;
  lru_pft_pkg::upd_t                upd;
  logic                             evict;

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign slot_free = !res_valid || !res_stall;

  // out-of-range counts clamp to 1..FRAMES
  always_comb begin
    if (frames_in_use == '0) begin
      n = NW'(1);
    end else if (32'(frames_in_use) > 32'(FRAMES)) begin
      n = NW'(FRAMES);
    end else begin
      n = NW'(frames_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use <= lru_pft_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      frames_in_use <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= page;
    end
  end

  assign carry_w[0] = '0;
  assign tok_w[0]   = start;

  for (genvar k = 0; k < FRAMES; k++) begin : g_cell
    lru_pft_cell #(
      .FRAMES   (FRAMES),
      .PAGE_BITS(PAGE_BITS),
      .IDX      (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .tok_in   (tok_w[k]),
      .carry_in (carry_w[k]),
      .req_page (req_page),
      .n        (n),
      .upd      (upd),
      .tok_out  (tok_w[k+1]),
      .carry_out(carry_w[k+1])
    );
  end

  assign c     = carry_w[FRAMES];
  assign evict = !c.found && !c.empty;

  always_comb begin
    upd      = '0;
    upd.en   = (state == ST_FIN) && slot_free;
    upd.wr   = !c.found;
    upd.page = lru_pft_pkg::PAGE_MAX_BITS'(req_page);
    if (c.found) begin
      upd.f   = c.fidx;
      upd.lim = {1'b0, c.frank};
    end else if (c.empty) begin
      // a fill ages every other resident frame
      upd.f   = c.eidx;
      upd.lim = (XW+1)'(FRAMES);
    end else begin
      upd.f   = c.vidx;
      upd.lim = {1'b0, c.vrank};
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_SCAN;
      ST_SCAN: if (tok_w[FRAMES]) state_next = ST_FIN;
      ST_FIN:  if (slot_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      start     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      if (upd.en) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd.en) begin
      hit           <= c.found;
      frame_index   <= upd.f[IW-1:0];
      evicted_valid <= evict;
      evicted_page  <= evict ? c.vpage[PAGE_BITS-1:0] : '0;
    end
  end

endmodule

// ===== sv/lru_pft_checker.sv =====
// port-level checks for the lru page frame table, bound to the top level
module lru_pft_checker #(
  parameter int FRAMES    = lru_pft_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lru_pft_pkg::PAGE_BITS_DEF,
  localparam int IW       = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic                 hit,
  input logic [IW-1:0]        frame_index,
  input logic                 evicted_valid,
  input logic [PAGE_BITS-1:0] evicted_page
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(hit) && $stable(frame_index)
      && $stable(evicted_valid) && $stable(evicted_page))
    else $error("result changed while stalled");

  a_evict_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && evicted_valid |-> !hit)
    else $error("eviction reported on a hit");

  a_evict_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !evicted_valid |-> evicted_page == '0)
    else $error("evicted page not zero without eviction");

  // one request in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken during a search");

  a_reset: assert property (@(posedge clk)
    rst |=> !res_valid && !req_stall)
    else $error("block not idle after reset");

endmodule

bind lru_page_frame_table_core lru_pft_checker #(
  .FRAMES   (FRAMES),
  .PAGE_BITS(PAGE_BITS)
) u_lru_pft_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .hit          (hit),
  .frame_index  (frame_index),
  .evicted_valid(evicted_valid),
  .evicted_page (evicted_page)
);

// ===== test/lru_page_frame_table_core_tb.sv =====
// testbench for the lru page frame table: directed and random page streams checked against a model
`timescale 1ns / 100ps

module lru_page_frame_table_core_tb;

  localparam int FRAMES    = lru_pft_pkg::FRAMES_DEF;
  localparam int PAGE_BITS = lru_pft_pkg::PAGE_BITS_DEF;
  localparam int IW        = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int HALF      = 10;
  localparam int LATENCY   = FRAMES + 4;
  localparam int LIMIT     = 400000;
  localparam int HOLD_LEN  = 300;

  typedef struct packed {
    logic                 hit;
    logic [IW-1:0]        frame;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
  } lookup_t;

  logic                                 clk;
  logic                                 rst;
  logic                                 cfg_wr_en;
  logic [lru_pft_pkg::CFG_BITS-1:0]     cfg_wr_data;
  logic                                 req_valid;
  logic                                 req_stall;
  logic [PAGE_BITS-1:0]                 page;
  logic                                 res_valid;
  logic                                 res_stall;
  logic                                 hit;
  logic [IW-1:0]                        frame_index;
  logic                                 evicted_valid;
  logic [PAGE_BITS-1:0]                 evicted_page;

  // model of the frame table
  logic [PAGE_BITS-1:0]             frame_pg [FRAMES];
  bit                               frame_vld [FRAMES];
  int                               frame_age [FRAMES];
  logic [lru_pft_pkg::CFG_BITS-1:0] frames_cfg;

  lookup_t expected_lookups [$];
  int      errors;
  int      cycles;
  int      snd_idle_pct;
  int      rcv_stall_pct;
  int      hold_pending;
  int      hold_left;

  lru_page_frame_table_core u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .page          (page),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
  );

  always begin
    clk = 1'b0;
    #(HALF);
    clk = 1'b1;
    #(HALF);
  end

  function automatic int active_frames();
    if (frames_cfg == 0) return 1;
    if (frames_cfg > FRAMES) return FRAMES;
    return int'(frames_cfg);
  endfunction

  // frame f becomes the youngest, valid active frames younger than limit age by one
  function automatic void make_recent(int f, int n, int limit);
    for (int i = 0; i < n; i++) begin
      if (i != f && frame_vld[i] && frame_age[i] < limit && frame_age[i] < FRAMES - 1)
        frame_age[i]++;
    end
    frame_age[f] = 0;
  endfunction

  function automatic lookup_t lookup_page(logic [PAGE_BITS-1:0] p);
    lookup_t r;
    int      n;
    int      f;
    int      lim;
    bit      found;
    bit      empty;
    r     = '0;
    n     = active_frames();
    f     = 0;
    found = 1'b0;
    empty = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (!found && frame_vld[i] && frame_pg[i] == p) begin
        f     = i;
        found = 1'b1;
      end
    end
    if (found) begin
      make_recent(f, n, frame_age[f]);
    end else begin
      for (int i = 0; i < n; i++) begin
        if (!empty && !frame_vld[i]) begin
          f     = i;
          empty = 1'b1;
        end
      end
      if (empty) begin
        frame_vld[f] = 1'b1;
        frame_pg[f]  = p;
        make_recent(f, n, FRAMES);
      end else begin
        // oldest active frame, lowest index on a tie
        f = 0;
        for (int i = 1; i < n; i++) begin
          if (frame_age[i] > frame_age[f]) f = i;
        end
        r.ev_valid  = 1'b1;
        r.ev_page   = frame_pg[f];
        lim         = frame_age[f];
        frame_pg[f] = p;
        make_recent(f, n, lim);
      end
    end
    r.hit   = found;
    r.frame = f[IW-1:0];
    return r;
  endfunction

  task automatic send_page(input logic [PAGE_BITS-1:0] p);
    int gap;
    req_valid <= 1'b1;
    page      <= p;
    do @(posedge clk); while (req_stall);
    expected_lookups.push_back(lookup_page(p));
    if ($urandom_range(99) < snd_idle_pct) begin
      gap = $urandom_range(1, FRAMES + 6);
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // pause the sender until every outstanding lookup has come back
  task automatic drain();
    req_valid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic set_frames(input int v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[lru_pft_pkg::CFG_BITS-1:0];
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    frames_cfg = v[lru_pft_pkg::CFG_BITS-1:0];
  endtask

  task automatic set_idling(input int snd, input int rcv);
    snd_idle_pct  = snd;
    rcv_stall_pct = rcv;
  endtask

  task automatic test_cold_fill();
    logic [PAGE_BITS-1:0] pages [8];
    pages = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
              16'h0001, 16'h8000, 16'h00FF, 16'hFF00};
    set_idling(0, 0);
    foreach (pages[i]) send_page(pages[i]);
  endtask

  task automatic test_hit_refresh();
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
  endtask

  task automatic test_eviction();
    send_page(16'h1234);
    send_page(16'h4321);
    send_page(16'h1234);
  endtask

  // out of range counts and frames parked outside the active range
  task automatic test_active_count();
    set_frames(0);
    send_page(16'h0F0F);
    set_frames(15);
    send_page(16'h0000);
    set_frames(2);
    send_page(16'hFFFF);
    send_page(16'h7777);
    set_frames(8);
    send_page(16'h5555);
  endtask

  task automatic test_backpressure();
    logic [PAGE_BITS-1:0] pool [6];
    set_frames(4);
    set_idling(0, 0);
    foreach (pool[i]) pool[i] = PAGE_BITS'($urandom);
    hold_pending = HOLD_LEN;
    for (int k = 0; k < 24; k++) send_page(pool[$urandom_range(5)]);
    drain();
  endtask

  task automatic run_phase(input int items, input int cfg, input int snd, input int rcv);
    logic [PAGE_BITS-1:0] pool [$];
    int                   n;
    int                   sel;
    set_frames(cfg);
    set_idling(snd, rcv);
    n = active_frames();
    repeat ($urandom_range(n, 2 * n + 2)) pool.push_back(PAGE_BITS'($urandom));
    for (int k = 0; k < items; k++) begin
      sel = $urandom_range(99);
      if (sel < 80)
        send_page(pool[$urandom_range(pool.size() - 1)]);
      else if (sel < 84)
        send_page($urandom_range(1) ? '1 : '0);
      else
        send_page(PAGE_BITS'($urandom));
    end
  endtask

  task automatic test_random_mix();
    int cfgs [12];
    int snds [4];
    int rcvs [4];
    cfgs = '{8, 1, 2, 3, 4, 5, 6, 7, 0, 15, 9, 8};
    snds = '{0, 46, 0, 11};
    rcvs = '{0, 0, 46, 11};
    foreach (cfgs[i]) run_phase(118, cfgs[i], snds[i % 4], rcvs[i % 4]);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    lookup_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t unexpected transfer hit=%0b frame=%0d evicted=%0b page=%0h",
                 $time, hit, frame_index, evicted_valid, evicted_page);
        errors++;
      end else begin
        want = expected_lookups.pop_front();
        check_field("hit", want.hit, hit);
        check_field("frame_index", want.frame, frame_index);
        check_field("evicted_valid", want.ev_valid, evicted_valid);
        check_field("evicted_page", want.ev_page, evicted_page);
      end
    end
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_pending > 0) begin
      hold_left    = hold_pending;
      hold_pending = 0;
    end
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      res_stall <= !rst && ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("lru_page_frame_table_core verification failed");
      $finish;
    end
  end

  initial begin
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    req_valid     = 1'b0;
    page          = '0;
    res_stall     = 1'b0;
    errors        = 0;
    cycles        = 0;
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    hold_pending  = 0;
    hold_left     = 0;
    frames_cfg    = lru_pft_pkg::CFG_RESET;
    foreach (frame_vld[i]) begin
      frame_vld[i] = 1'b0;
      frame_age[i] = 0;
      frame_pg[i]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_cold_fill();
    test_hit_refresh();
    test_eviction();
    test_active_count();
    test_backpressure();
    test_random_mix();

    drain();
    if (errors == 0) begin
      $display("lru_page_frame_table_core verification clean");
    end else begin
      $display("lru_page_frame_table_core verification failed");
    end
    $finish;
  end

endmodule
